// File: sv/assert_macros.svh
// Shared assertion macros for the root solver.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an expression on every enabled clock edge.
`define MQR_ASSERT(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("assertion failed");

// Check that a condition implies a consequence in the same cycle.
`define MQR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication failed");

`endif

// File: sv/mqr_pkg.sv
`default_nettype none

package mqr_pkg;

    // Root fields are signed, fixed 40 bits wide.
    localparam int OUT_WIDTH = 40;

    // Per-item status carried to the output.
    typedef struct packed {
        logic real_roots;
        logic polish_skipped;
    } t_flags;

endpackage

`default_nettype wire

// File: sv/mqr_front.sv
`default_nettype none

module mqr_front
    import mqr_pkg::*;
#(
    parameter int FRAC_BITS  = 16,
    parameter int COEF_WIDTH = 32,
    parameter int AW         = 64
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic                         i_valid,
    input  wire logic signed [COEF_WIDTH-1:0] i_coef_b,
    input  wire logic signed [COEF_WIDTH-1:0] i_coef_c,
    output logic                              o_valid,
    output logic             [AW-1:0]         o_disc,
    output logic                              o_real,
    output logic signed      [COEF_WIDTH+1:0] o_nb2
);

    localparam int W = COEF_WIDTH;

    // stage 1: capture coefficients
    logic                r_v1;
    logic signed [W-1:0] r_b1;
    logic signed [W-1:0] r_c1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b1 <= i_coef_b;
            r_c1 <= i_coef_c;
        end
    end

    // stage 2: square |b| and scale |c|
    logic [W-1:0]   w_bmag;
    logic [W-1:0]   w_cmag;
    logic [2*W-1:0] w_sq;
    logic [AW-1:0]  n_sq2;
    logic [AW-1:0]  n_p2;

    assign w_bmag = r_b1[W-1] ? W'(-r_b1) : W'(r_b1);
    assign w_cmag = r_c1[W-1] ? W'(-r_c1) : W'(r_c1);
    assign w_sq   = w_bmag * w_bmag;
    assign n_sq2  = AW'(w_sq);
    assign n_p2   = AW'(w_cmag) << (FRAC_BITS + 2);

    logic                r_v2;
    logic [AW-1:0]       r_sq2;
    logic [AW-1:0]       r_p2;
    logic                r_cpos2;
    logic signed [W-1:0] r_b2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq2   <= n_sq2;
            r_p2    <= n_p2;
            r_cpos2 <= !r_c1[W-1] && (r_c1 != '0);
            r_b2    <= r_b1;
        end
    end

    // stage 3: discriminant magnitude and its sign
    logic                n_real;
    logic [AW-1:0]       n_disc;
    logic signed [W+1:0] w_bx;

    always_comb begin
        if (!r_cpos2) begin
            n_real = 1'b1;
            n_disc = r_sq2 + r_p2;
        end else if (r_sq2 >= r_p2) begin
            n_real = 1'b1;
            n_disc = r_sq2 - r_p2;
        end else begin
            n_real = 1'b0;
            n_disc = r_p2 - r_sq2;
        end
    end

    assign w_bx = (W+2)'(r_b2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_disc <= n_disc;
            o_real <= n_real;
            o_nb2  <= -(w_bx <<< 1);
        end
    end

endmodule

`default_nettype wire

// File: sv/mqr_sqrt_step.sv
`default_nettype none

module mqr_sqrt_step
    import mqr_pkg::*;
#(
    parameter int AW     = 64,
    parameter int SW     = 32,
    parameter int K      = 0,
    parameter int SIDE_W = 35
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [AW-1:0]     i_rem,
    input  wire logic [SW-1:0]     i_root,
    input  wire logic [SIDE_W-1:0] i_side,
    output logic                   o_valid,
    output logic      [AW-1:0]     o_rem,
    output logic      [SW-1:0]     o_root,
    output logic      [SIDE_W-1:0] o_side
);

    // trial term: (root + 2^K)^2 - root^2 = root*2^(K+1) + 2^(2K)
    logic [AW:0] w_trial;
    logic        w_take;

    assign w_trial = ((AW+1)'(i_root) << (K + 1)) | ((AW+1)'(1) << (2 * K));
    assign w_take  = {1'b0, i_rem} >= w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    // keep the bit when the remainder allows it
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_side <= i_side;
            if (w_take) begin
                o_rem  <= i_rem - w_trial[AW-1:0];
                o_root <= i_root | (SW'(1) << K);
            end else begin
                o_rem  <= i_rem;
                o_root <= i_root;
            end
        end
    end

endmodule

`default_nettype wire

// File: sv/mqr_back.sv
`default_nettype none

module mqr_back
    import mqr_pkg::*;
#(
    parameter int COEF_WIDTH = 32,
    parameter int AW         = 64,
    parameter int SW         = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic                         i_valid,
    input  wire logic        [AW-1:0]         i_rem,
    input  wire logic        [SW-1:0]         i_root,
    input  wire logic                         i_real,
    input  wire logic signed [COEF_WIDTH+1:0] i_nb2,
    output logic                              o_valid,
    output logic signed      [OUT_WIDTH-1:0]  o_re0,
    output logic signed      [OUT_WIDTH-1:0]  o_im0,
    output logic signed      [OUT_WIDTH-1:0]  o_re1,
    output logic signed      [OUT_WIDTH-1:0]  o_im1,
    output t_flags                            o_flags
);

    localparam int VW0 = (COEF_WIDTH + 2 > SW + 3) ? COEF_WIDTH + 2 : SW + 3;
    localparam int VW  = VW0 + 1;
    localparam int CW  = ((VW > OUT_WIDTH) ? VW : OUT_WIDTH) + 1;
    localparam logic signed [CW-1:0] SAT_HI = (CW'(1) << (OUT_WIDTH - 1)) - CW'(1);
    localparam logic signed [CW-1:0] SAT_LO = -SAT_HI - CW'(1);

    // stage A: Newton-corrected root width and pre-round values
    logic              w_skip;
    logic [1:0]        w_q;
    logic [SW+1:0]     w_m;
    logic signed [VW-1:0] w_mx;
    logic signed [VW-1:0] w_nbx;

    assign w_skip = (i_root == '0);
    always_comb begin
        if (i_rem >= (AW'(i_root) << 1)) begin
            w_q = 2'd2;
        end else if (i_rem >= AW'(i_root)) begin
            w_q = 2'd1;
        end else begin
            w_q = 2'd0;
        end
    end
    assign w_m   = w_skip ? '0 : ((SW+2)'(i_root) << 1) + (SW+2)'(w_q);
    assign w_mx  = signed'(VW'(w_m));
    assign w_nbx = VW'(i_nb2);

    logic                 r_va;
    logic signed [VW-1:0] r_v0;
    logic signed [VW-1:0] r_v1;
    logic signed [VW-1:0] r_vi;
    t_flags               r_fa;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v0                <= i_real ? w_nbx + w_mx : w_nbx;
            r_v1                <= i_real ? w_nbx - w_mx : w_nbx;
            r_vi                <= i_real ? '0 : w_mx;
            r_fa.real_roots     <= i_real;
            r_fa.polish_skipped <= w_skip;
        end
    end

    // round to nearest (ties up) dropping two bits, then clamp
    function automatic logic signed [OUT_WIDTH-1:0] rnd_sat(input logic signed [VW-1:0] v);
        logic signed [CW-1:0] t;
        logic signed [CW-1:0] q;
        t = CW'(v) + CW'(2);
        q = t >>> 2;
        if (q > SAT_HI) begin
            q = SAT_HI;
        end else if (q < SAT_LO) begin
            q = SAT_LO;
        end
        return q[OUT_WIDTH-1:0];
    endfunction

    // stage B: output register
    logic signed [OUT_WIDTH-1:0] w_im0;
    assign w_im0 = rnd_sat(r_vi);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_re0   <= rnd_sat(r_v0);
            o_re1   <= rnd_sat(r_v1);
            o_im0   <= w_im0;
            o_im1   <= -w_im0;
            o_flags <= r_fa;
        end
    end

endmodule

`default_nettype wire

// File: sv/monic_quadratic_root_solver.sv
// Channel  | Handshake           | Payload
// ---------+---------------------+-----------------------------------------------
// input    | i_valid / o_ready   | i_coef_b, i_coef_c
// output   | o_valid / i_ready   | o_root0/1_re/im, o_real_roots, o_polish_skipped
//
// One coefficient pair is taken per cycle unless the output stalls; the path
// runs through three front stages, one stage per square-root bit (SW, half the
// discriminant width), and two back stages for correction and rounding.
// Reset is synchronous, active low, and clears all valid bits.
// A stall on the output freezes the whole pipeline at once, so o_ready falls.
`default_nettype none

module monic_quadratic_root_solver
    import mqr_pkg::*;
#(
    parameter int FRAC_BITS  = 16,
    parameter int COEF_WIDTH = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic signed [COEF_WIDTH-1:0] i_coef_b,
    input  wire logic signed [COEF_WIDTH-1:0] i_coef_c,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic signed      [OUT_WIDTH-1:0]  o_root0_re,
    output logic signed      [OUT_WIDTH-1:0]  o_root0_im,
    output logic signed      [OUT_WIDTH-1:0]  o_root1_re,
    output logic signed      [OUT_WIDTH-1:0]  o_root1_im,
    output logic                              o_real_roots,
    output logic                              o_polish_skipped
);

`include "assert_macros.svh"

    localparam int AW0    = (2 * COEF_WIDTH > COEF_WIDTH + FRAC_BITS + 2)
                          ? 2 * COEF_WIDTH : COEF_WIDTH + FRAC_BITS + 2;
    localparam int AW     = AW0 + (AW0 % 2);
    localparam int SW     = AW / 2;
    localparam int SIDE_W = COEF_WIDTH + 3;

    // advance every stage unless the output holds an untaken result
    logic w_en;
    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    logic                         w_fv;
    logic        [AW-1:0]         w_disc;
    logic                         w_real;
    logic signed [COEF_WIDTH+1:0] w_nb2;

    mqr_front #(
        .FRAC_BITS  (FRAC_BITS),
        .COEF_WIDTH (COEF_WIDTH),
        .AW         (AW)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (i_valid),
        .i_coef_b (i_coef_b),
        .i_coef_c (i_coef_c),
        .o_valid  (w_fv),
        .o_disc   (w_disc),
        .o_real   (w_real),
        .o_nb2    (w_nb2)
    );

    // square root, one result bit per stage, most significant first
    logic              s_v    [SW+1];
    logic [AW-1:0]     s_rem  [SW+1];
    logic [SW-1:0]     s_root [SW+1];
    logic [SIDE_W-1:0] s_side [SW+1];

    assign s_v[0]    = w_fv;
    assign s_rem[0]  = w_disc;
    assign s_root[0] = '0;
    assign s_side[0] = {w_real, w_nb2};

    for (genvar g = 0; g < SW; g++) begin : g_sqrt
        mqr_sqrt_step #(
            .AW     (AW),
            .SW     (SW),
            .K      (SW - 1 - g),
            .SIDE_W (SIDE_W)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (s_v[g]),
            .i_rem   (s_rem[g]),
            .i_root  (s_root[g]),
            .i_side  (s_side[g]),
            .o_valid (s_v[g+1]),
            .o_rem   (s_rem[g+1]),
            .o_root  (s_root[g+1]),
            .o_side  (s_side[g+1])
        );
    end

    t_flags w_flags;

    mqr_back #(
        .COEF_WIDTH (COEF_WIDTH),
        .AW         (AW),
        .SW         (SW)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (s_v[SW]),
        .i_rem   (s_rem[SW]),
        .i_root  (s_root[SW]),
        .i_real  (s_side[SW][SIDE_W-1]),
        .i_nb2   (signed'(s_side[SW][COEF_WIDTH+1:0])),
        .o_valid (o_valid),
        .o_re0   (o_root0_re),
        .o_im0   (o_root0_im),
        .o_re1   (o_root1_re),
        .o_im1   (o_root1_im),
        .o_flags (w_flags)
    );

    assign o_real_roots     = w_flags.real_roots;
    assign o_polish_skipped = w_flags.polish_skipped;

    `MQR_ASSERT_IMP(a_skip_real, i_clk, i_rst_n, o_valid && o_polish_skipped, o_real_roots)
    `MQR_ASSERT_IMP(a_real_no_im, i_clk, i_rst_n, o_valid && o_real_roots,
                    o_root0_im == '0 && o_root1_im == '0)
    `MQR_ASSERT_IMP(a_cplx_conj, i_clk, i_rst_n, o_valid && !o_real_roots,
                    o_root0_re == o_root1_re && o_root1_im == -o_root0_im)
    `MQR_ASSERT_IMP(a_skip_double, i_clk, i_rst_n, o_valid && o_polish_skipped,
                    o_root0_re == o_root1_re)

endmodule

`default_nettype wire

// File: test/tb.sv
`default_nettype none

module tb
    import mqr_pkg::*;
;

    localparam int FRAC_BITS   = 16;
    localparam int COEF_WIDTH  = 32;
    localparam int LATENCY     = 40;
    localparam int WATCH_LIMIT = 20000;

    typedef struct {
        logic signed [OUT_WIDTH-1:0] r0_re;
        logic signed [OUT_WIDTH-1:0] r0_im;
        logic signed [OUT_WIDTH-1:0] r1_re;
        logic signed [OUT_WIDTH-1:0] r1_im;
        logic                        real_roots;
        logic                        polish_skipped;
    } t_roots;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    logic signed [COEF_WIDTH-1:0] i_coef_b = '0;
    logic signed [COEF_WIDTH-1:0] i_coef_c = '0;
    logic o_ready, o_valid, o_real_roots, o_polish_skipped;
    logic signed [OUT_WIDTH-1:0] o_root0_re, o_root0_im, o_root1_re, o_root1_im;

    t_roots pending_roots[$];
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    int     idle_cycles = 0;
    bit     failed = 1'b0;

    monic_quadratic_root_solver #(.FRAC_BITS(FRAC_BITS), .COEF_WIDTH(COEF_WIDTH)) dut (.*);

    always #6 i_clk = ~i_clk;

    // Round from F+2 to F fraction bits, ties up, then clamp to the output range
    function automatic logic signed [OUT_WIDTH-1:0] round_clamp(logic signed [127:0] v);
        logic signed [127:0] q;
        logic signed [127:0] top;
        top = (128'sd1 <<< (OUT_WIDTH - 1)) - 1;
        q = (v + 2) >>> 2;
        if (q > top) q = top;
        if (q < -top - 1) q = -top - 1;
        return q[OUT_WIDTH-1:0];
    endfunction

    function automatic t_roots solve_roots(logic signed [COEF_WIDTH-1:0] b,
                                           logic signed [COEF_WIDTH-1:0] c);
        t_roots res;
        logic signed [127:0] disc, nb2, m;
        logic [127:0] amag, s, cand, rem;
        disc = $signed(128'(b)) * $signed(128'(b))
             - ($signed(128'(c)) <<< (FRAC_BITS + 2));
        amag = disc < 0 ? -disc : disc;
        s = 0;
        for (int k = 63; k >= 0; k--) begin
            cand = s | (128'd1 << k);
            if (cand * cand <= amag) s = cand;
        end
        rem = amag - s * s;
        res.polish_skipped = (s == 0);
        if (s == 0) m = 0;
        else m = 2 * s + (rem >= 2 * s ? 2 : (rem >= s ? 1 : 0));
        nb2 = -2 * $signed(128'(b));
        res.real_roots = (disc >= 0);
        if (res.real_roots) begin
            res.r0_re = round_clamp(nb2 + m);
            res.r1_re = round_clamp(nb2 - m);
            res.r0_im = '0;
            res.r1_im = '0;
        end else begin
            res.r0_re = round_clamp(nb2);
            res.r1_re = res.r0_re;
            res.r0_im = round_clamp(m);
            res.r1_im = -res.r0_im;
        end
        return res;
    endfunction

    // Drive one coefficient pair and hold it until the transfer
    task automatic send_coefs(logic signed [COEF_WIDTH-1:0] b,
                              logic signed [COEF_WIDTH-1:0] c);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_coef_b <= b;
        i_coef_c <= c;
        i_valid  <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_roots.push_back(solve_roots(b, c));
        @(negedge i_clk);
    endtask

    // Randomize receiver backpressure at the falling edge
    always @(negedge i_clk)
        i_ready <= ($urandom_range(99) >= recv_idle_pct);

    // Compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_roots exp_r;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_roots.size() == 0) begin
                $error("unexpected result");
                failed = 1'b1;
            end else begin
                exp_r = pending_roots.pop_front();
                if (o_root0_re !== exp_r.r0_re) begin
                    $error("root0_re exp %0d got %0d", exp_r.r0_re, o_root0_re);
                    failed = 1'b1;
                end
                if (o_root0_im !== exp_r.r0_im) begin
                    $error("root0_im exp %0d got %0d", exp_r.r0_im, o_root0_im);
                    failed = 1'b1;
                end
                if (o_root1_re !== exp_r.r1_re) begin
                    $error("root1_re exp %0d got %0d", exp_r.r1_re, o_root1_re);
                    failed = 1'b1;
                end
                if (o_root1_im !== exp_r.r1_im) begin
                    $error("root1_im exp %0d got %0d", exp_r.r1_im, o_root1_im);
                    failed = 1'b1;
                end
                if (o_real_roots !== exp_r.real_roots) begin
                    $error("real_roots exp %0d got %0d", exp_r.real_roots, o_real_roots);
                    failed = 1'b1;
                end
                if (o_polish_skipped !== exp_r.polish_skipped) begin
                    $error("polish_skipped exp %0d got %0d",
                           exp_r.polish_skipped, o_polish_skipped);
                    failed = 1'b1;
                end
            end
        end
    end

    // Watchdog: count cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Drop valid and hold until every expected result has come
    task automatic wait_drain();
        i_valid <= 1'b0;
        while (pending_roots.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic test_corners();
        logic signed [COEF_WIDTH-1:0] ext[5];
        ext = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sd0, -32'sd1, 32'sd1};
        foreach (ext[i])
            foreach (ext[j]) send_coefs(ext[i], ext[j]);
    endtask

    task automatic test_special();
        // double roots: c = b^2/4
        send_coefs(32'sd4 << 16, 32'sd4 << 16);
        send_coefs(-(32'sd6 << 16), 32'sd9 << 16);
        send_coefs(32'sd0, 32'sd0);
        // complex pair and large real roots
        send_coefs(32'sd0, 32'sd1 << 16);
        send_coefs(32'sd2 << 16, 32'sd5 << 16);
        send_coefs(32'sh8000_0000, 32'sh8000_0000);
    endtask

    task automatic test_random(int count);
        logic signed [COEF_WIDTH-1:0] b, c;
        logic signed [63:0] h;
        for (int n = 0; n < count; n++) begin
            b = $urandom;
            case ($urandom_range(4))
                0: c = $urandom;
                1: begin
                    // double root: pick small even b so b^2/4 fits in Q16.16
                    b = $signed(b) >>> 24;
                    b = b & ~32'sd1;
                    h = ($signed(64'(b)) * $signed(64'(b))) >>> 2;
                    b = b <<< 16;
                    c = 32'(h <<< 16);
                end
                2: begin
                    b = $signed(b) >>> $urandom_range(20, 8);
                    c = $signed(32'($urandom)) >>> $urandom_range(20, 4);
                end
                3: begin
                    b = $signed(b) >>> 12;
                    c = 32'((($signed(64'(b)) * $signed(64'(b))) >>> 18)
                        + $signed(64'($urandom_range(7))) - 3);
                end
                default: c = -$signed(32'($urandom_range(1 << 20)));
            endcase
            send_coefs(b, c);
        end
    endtask

    task automatic test_drain_pause();
        test_random(20);
        wait_drain();
        test_random(20);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 8;
        recv_idle_pct = 48;
        test_corners();
        test_special();
        test_random(200);
        send_idle_pct = 48;
        recv_idle_pct = 8;
        test_drain_pause();
        test_random(200);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(230);
        wait_drain();
        repeat (LATENCY) @(posedge i_clk);
        if (!failed && pending_roots.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
